[rtl/conv5x5_scale_relu_assert.svh]
// Assertion macros for the conv5x5_scale_relu block.
// No dependencies; included by c5sr_ctrl, which checks its own control logic.
`ifndef CONV5X5_SCALE_RELU_ASSERT_SVH
`define CONV5X5_SCALE_RELU_ASSERT_SVH
`ifndef ASSERT_OFF
`define C5SR_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("c5sr assertion failed");
`define C5SR_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("c5sr assertion failed");
`else
`define C5SR_ASSERT_IMP(label, clk, rst_n, a, c)
`define C5SR_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

[rtl/c5sr_pkg.sv]
// Shared constants, codes and controller/datapath interface types for conv5x5_scale_relu.
// No dependencies.
`default_nettype none
package c5sr_pkg;
	localparam int KS        = 5;
	localparam int TAPS      = KS * KS;
	localparam int LINES     = KS - 1;
	localparam int MAX_WIDTH_DEF = 64;

	localparam logic MODE_WEIGHT = 1'b0;
	localparam logic MODE_PIXEL  = 1'b1;

	localparam logic [1:0] CFG_WIDTH = 2'd0;
	localparam logic [1:0] CFG_SCALE = 2'd1;
	localparam logic [1:0] CFG_SHIFT = 2'd2;

	localparam logic [15:0] IMAGE_WIDTH_RST = 16'd28;
	localparam logic [15:0] SCALE_RST       = 16'd16384;
	localparam logic [5:0]  SHIFT_RST       = 6'd14;

	typedef struct packed {
		logic       load_pix;   // latch pixel of accepted transaction
		logic       wr_weight;  // store weight of accepted transaction
		logic       rd_en;      // issue line store read
		logic [1:0] rd_k;       // line being read
		logic       cap_en;     // capture registered read data
		logic [1:0] cap_k;
		logic       shift;      // shift window, write line store, step counters
		logic       mul_en;
		logic [4:0] tap;
		logic       acc_add;
		logic       scale_mul;
		logic       sum;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

[rtl/c5sr_dpath.sv]
// Datapath: config registers, weights, line store, window, MAC, scale, clamp, output register.
// Depends on c5sr_pkg.
`default_nettype none
module c5sr_dpath #(
	parameter int MAX_WIDTH = c5sr_pkg::MAX_WIDTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire [1:0]           cfg_index,
	input  wire [15:0]          cfg_data,
	input  wire [4:0]           weight_index,
	input  wire [15:0]          weight_value,
	input  wire [15:0]          pixel,
	input  c5sr_pkg::cmd_t      cmd,
	output c5sr_pkg::sts_t      sts,
	input  wire                 result_stall,
	output logic                result_valid,
	output logic [15:0]         out_value,
	output logic                last
);
	import c5sr_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = ($clog2(MAX_WIDTH + 1) > 7) ? $clog2(MAX_WIDTH + 1) : 7;
	localparam int DEPTH = LINES * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);

	logic [6:0]         width_q;
	logic signed [15:0] scale_q;
	logic [5:0]         shift_q;
	logic signed [15:0] wt_q [TAPS];
	logic [15:0]        win_q [TAPS];
	logic [15:0]        colbuf_q [LINES];
	logic [15:0]        pix_q;
	logic [CW-1:0]      row_q, col_q;
	logic [15:0]        mem [DEPTH];
	logic [15:0]        rdata_q;
	logic signed [32:0] prod_s1;
	logic signed [36:0] acc_q;
	logic signed [36:0] plo_q;
	logic signed [32:0] phi_q;
	logic signed [52:0] sp_q;
	logic               is_last_q;
	logic               out_valid_q;
	logic [15:0]        out_value_q;
	logic               last_q;

	logic [WW-1:0] w_eff, col_nx, row_nx;
	logic          col_end, row_end;
	logic [1:0]    rd_slot;
	logic [AW-1:0] raddr, waddr;
	logic [52:0]   shifted;
	logic [15:0]   clamp_val;

	always_comb begin
		if (WW'(width_q) < WW'(KS))
			w_eff = WW'(KS);
		else if (WW'(width_q) > WW'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(width_q);
		col_nx  = WW'(col_q) + WW'(1);
		row_nx  = WW'(row_q) + WW'(1);
		col_end = col_nx >= w_eff;
		row_end = row_nx >= w_eff;
		rd_slot = row_q[1:0] + cmd.rd_k;
		raddr   = AW'(AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(col_q));
		waddr   = AW'(AW'(row_q[1:0]) * AW'(MAX_WIDTH) + AW'(col_q));
		shifted = $unsigned(sp_q) >> shift_q;
		if (sp_q <= 53'sd0)
			clamp_val = 16'd0;
		else if (|shifted[52:16])
			clamp_val = 16'hFFFF;
		else
			clamp_val = shifted[15:0];
	end

	assign sts.emit     = (WW'(row_q) >= WW'(LINES)) && (WW'(col_q) >= WW'(LINES));
	assign sts.out_free = !out_valid_q || !result_stall;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= IMAGE_WIDTH_RST[6:0];
			scale_q <= SCALE_RST;
			shift_q <= SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH: width_q <= cfg_data[6:0];
				CFG_SCALE: scale_q <= cfg_data;
				CFG_SHIFT: shift_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// weights, window and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				wt_q[i]  <= '0;
				win_q[i] <= '0;
			end
			row_q <= '0;
			col_q <= '0;
		end else begin
			if (cmd.wr_weight && (weight_index < 5'(TAPS)))
				wt_q[weight_index] <= weight_value;
			if (cmd.shift) begin
				for (int r = 0; r < KS; r++) begin
					for (int c = 0; c < KS - 1; c++)
						win_q[r*KS + c] <= win_q[r*KS + c + 1];
				end
				for (int r = 0; r < LINES; r++)
					win_q[r*KS + KS - 1] <= colbuf_q[r];
				win_q[TAPS-1] <= pix_q;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : CW'(row_nx);
				end else begin
					col_q <= CW'(col_nx);
				end
			end
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (cmd.rd_en)
			rdata_q <= mem[raddr];
		if (cmd.shift)
			mem[waddr] <= pix_q;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_pix)
			pix_q <= pixel;
		if (cmd.cap_en)
			colbuf_q[cmd.cap_k] <= rdata_q;
		if (cmd.shift) begin
			is_last_q <= col_end && row_end;
			acc_q     <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + 37'(prod_s1);
		end
		if (cmd.mul_en)
			prod_s1 <= wt_q[cmd.tap] * $signed({1'b0, win_q[cmd.tap]});
		if (cmd.scale_mul) begin
			plo_q <= $signed({1'b0, acc_q[19:0]}) * scale_q;
			phi_q <= $signed(acc_q[36:20]) * scale_q;
		end
		if (cmd.sum)
			sp_q <= $signed({phi_q, 20'd0}) + 53'(plo_q);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!result_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q <= clamp_val;
			last_q      <= is_last_q;
		end
	end

	assign result_valid = out_valid_q;
	assign out_value    = out_value_q;
	assign last         = last_q;
endmodule
`default_nettype wire

[rtl/c5sr_ctrl.sv]
// Controller: sequences line store reads, window update, tap MAC, scaling and output.
// Depends on c5sr_pkg and conv5x5_scale_relu_assert.svh.
`default_nettype none
module c5sr_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            item_valid,
	input  wire            mode,
	output logic           item_stall,
	input  c5sr_pkg::sts_t sts,
	output c5sr_pkg::cmd_t cmd
);
	import c5sr_pkg::*;
	`include "conv5x5_scale_relu_assert.svh"

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_SHIFT, ST_MAC, ST_SCALE, ST_SUM, ST_OUT
	} state_t;

	state_t     state_q;
	logic [2:0] k_q;
	logic [4:0] tap_q;
	logic       accept;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		cmd           = '0;
		cmd.wr_weight = accept && (mode == MODE_WEIGHT);
		cmd.load_pix  = accept && (mode == MODE_PIXEL);
		cmd.rd_en     = (state_q == ST_READ) && (k_q < 3'(LINES));
		cmd.rd_k      = k_q[1:0];
		cmd.cap_en    = (state_q == ST_READ) && (k_q != 3'd0);
		cmd.cap_k     = 2'(k_q - 3'd1);
		cmd.shift     = (state_q == ST_SHIFT);
		cmd.mul_en    = (state_q == ST_MAC) && (tap_q < 5'(TAPS));
		cmd.tap       = tap_q;
		cmd.acc_add   = (state_q == ST_MAC) && (tap_q != 5'd0);
		cmd.scale_mul = (state_q == ST_SCALE);
		cmd.sum       = (state_q == ST_SUM);
		cmd.out_load  = (state_q == ST_OUT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			tap_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (accept && (mode == MODE_PIXEL))
						state_q <= ST_READ;
				end
				ST_READ: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'(LINES))
						state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					tap_q   <= '0;
					state_q <= sts.emit ? ST_MAC : ST_IDLE;
				end
				ST_MAC: begin
					tap_q <= tap_q + 5'd1;
					if (tap_q == 5'(TAPS))
						state_q <= ST_SCALE;
				end
				ST_SCALE: state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_OUT;
				ST_OUT: begin
					if (sts.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`C5SR_ASSERT_NXT(a_pix_starts_read, clk, arst_n, accept && (mode == MODE_PIXEL), state_q == ST_READ)
	`C5SR_ASSERT_NXT(a_wt_stays_idle, clk, arst_n, accept && (mode == MODE_WEIGHT), state_q == ST_IDLE)
	`C5SR_ASSERT_IMP(a_tap_bound, clk, arst_n, state_q == ST_MAC, tap_q <= 5'(TAPS))
	`C5SR_ASSERT_IMP(a_out_only_free, clk, arst_n, cmd.out_load, sts.out_free && (state_q == ST_OUT))
endmodule
`default_nettype wire

[rtl/conv5x5_scale_relu.sv]
// Streaming 5x5 valid convolution with scale, right shift, ReLU and 16-bit saturation.
// Pixels arrive in raster order; weight transactions (mode 0) load taps and give no result.
// A pixel transaction makes four reads through the single line store read port, captures
// each word and updates the window; a pixel inside the valid region then runs the tap
// MAC on the one shared multiplier, scales, clamps and waits for a free output register
// before the next transaction is taken. A weight transaction leaves the controller idle.
// A finished result waits in the output register while the next transaction is worked
// on. No clearing pass. Depends on c5sr_pkg, c5sr_ctrl and c5sr_dpath.
`default_nettype none
module conv5x5_scale_relu #(
	parameter int MAX_WIDTH = c5sr_pkg::MAX_WIDTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [1:0]  cfg_index,
	input  wire [15:0] cfg_data,
	input  wire        item_valid,
	output logic       item_stall,
	input  wire        mode,
	input  wire [4:0]  weight_index,
	input  wire [15:0] weight_value,
	input  wire [15:0] pixel,
	output logic       result_valid,
	input  wire        result_stall,
	output logic [15:0] out_value,
	output logic       last
);
	import c5sr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	c5sr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.mode       (mode),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	c5sr_dpath #(.MAX_WIDTH(MAX_WIDTH)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.weight_index (weight_index),
		.weight_value (weight_value),
		.pixel        (pixel),
		.cmd          (cmd),
		.sts          (sts),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.out_value    (out_value),
		.last         (last)
	);
endmodule
`default_nettype wire
